FILE: hw/rtl/nfcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_pkg
// Shared types, codes and the microcode table of the NOR flash command
// sequencer.
// ----------------------------------------------------------------------------
package nfcs_pkg;

    // Default address latch timing.
    localparam int ALE_HIGH_CYCLES_DEF = 12;
    localparam int ALE_LOW_CYCLES_DEF  = 2;

    localparam int AD_W   = 19;
    localparam int T_W    = 24;
    localparam int SS_W   = 17;
    localparam int EC_W   = 16;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;
    localparam int PC_W   = 6;

    // Operation codes.
    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_PROGRAM  = 3'd1;
    localparam logic [2:0] CMD_SE_ERASE = 3'd2;
    localparam logic [2:0] CMD_CH_ERASE = 3'd3;
    localparam logic [2:0] CMD_IDENTIFY = 3'd4;

    // Phase codes.
    localparam logic [2:0] PH_LATCH = 3'd0;
    localparam logic [2:0] PH_WRITE = 3'd1;
    localparam logic [2:0] PH_READ  = 3'd2;
    localparam logic [2:0] PH_PROG  = 3'd3;
    localparam logic [2:0] PH_WAIT  = 3'd4;

    // Lane codes.
    localparam logic [1:0] LANE_HI   = 2'd0;
    localparam logic [1:0] LANE_LO   = 2'd1;
    localparam logic [1:0] LANE_NONE = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_T_READ      = 3'd0;
    localparam logic [IDX_W-1:0] REG_T_WPULSE    = 3'd1;
    localparam logic [IDX_W-1:0] REG_T_PROGRAM   = 3'd2;
    localparam logic [IDX_W-1:0] REG_T_ID_ACCESS = 3'd3;
    localparam logic [IDX_W-1:0] REG_T_SE_ERASE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_T_CH_ERASE  = 3'd5;
    localparam logic [IDX_W-1:0] REG_SECTOR_SIZE = 3'd6;
    localparam logic [IDX_W-1:0] REG_ERASE_CODE  = 3'd7;

    // Register reset values.
    localparam logic [T_W-1:0]  RST_T_READ      = 24'd9;
    localparam logic [T_W-1:0]  RST_T_WPULSE    = 24'd5;
    localparam logic [T_W-1:0]  RST_T_PROGRAM   = 24'd2500;
    localparam logic [T_W-1:0]  RST_T_ID_ACCESS = 24'd19;
    localparam logic [T_W-1:0]  RST_T_SE_ERASE  = 24'd3125000;
    localparam logic [T_W-1:0]  RST_T_CH_ERASE  = 24'd12500000;
    localparam logic [SS_W-1:0] RST_SECTOR_SIZE = 17'd16384;
    localparam logic [EC_W-1:0] RST_ERASE_CODE  = 16'h3030;

    // Bus addresses and command words.
    localparam logic [15:0] ADDR_UNLOCK1   = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK2   = 16'h2AAA;
    localparam logic [15:0] DATA_UNLOCK1   = 16'hAAAA;
    localparam logic [15:0] DATA_UNLOCK2   = 16'h5555;
    localparam logic [15:0] CW_PROGRAM     = 16'hA0A0;
    localparam logic [15:0] CW_ERASE_SETUP = 16'h8080;
    localparam logic [15:0] CW_CHIP_ERASE  = 16'h1010;
    localparam logic [15:0] CW_ID_ENTRY    = 16'h9090;
    localparam logic [15:0] CW_ID_EXIT     = 16'hF0F0;
    localparam logic [15:0] ADDR_ID_WORD0  = 16'h0000;
    localparam logic [15:0] ADDR_ID_WORD1  = 16'h0001;

    typedef enum logic [2:0] {
        AD_IMM   = 3'd0,
        AD_WADDR = 3'd1,
        AD_EADDR = 3'd2,
        AD_DATA  = 3'd3,
        AD_ECODE = 3'd4
    } t_ad_sel;

    typedef enum logic [1:0] {
        LS_HI   = 2'd0,
        LS_LO   = 2'd1,
        LS_NONE = 2'd2,
        LS_HALF = 2'd3
    } t_lane_sel;

    typedef enum logic [1:0] {
        PS_ZERO = 2'd0,
        PS_ALE  = 2'd1,
        PS_TWP  = 2'd2,
        PS_TRD  = 2'd3
    } t_pulse_sel;

    typedef enum logic [2:0] {
        RS_ALE   = 3'd0,
        RS_TWP   = 3'd1,
        RS_TRD   = 3'd2,
        RS_TPROG = 3'd3,
        RS_TID   = 3'd4,
        RS_TSE   = 3'd5,
        RS_TCE   = 3'd6
    } t_rec_sel;

    // One microcode word.
    typedef struct packed {
        logic [2:0]      ph;
        t_ad_sel         ad_sel;
        logic [15:0]     imm;
        t_lane_sel       lane_sel;
        t_pulse_sel      pulse_sel;
        t_rec_sel        rec_sel;
        logic            loop;
        logic [PC_W-1:0] target;
        logic            last;
    } t_uword;

    // Sequencer to datapath control.
    typedef struct packed {
        logic   issue;
        logic   half;
        t_uword uw;
    } t_ctl;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [20:0] byte_addr;
        logic [31:0] data_word;
        logic [9:0]  sector;
    } t_req;

    typedef struct packed {
        logic [2:0]      phase;
        logic [AD_W-1:0] ad_value;
        logic [1:0]      lanes;
        logic [T_W-1:0]  pulse_cycles;
        logic [T_W-1:0]  recovery_cycles;
        logic            last;
    } t_res;

    // Microcode layout.
    localparam int CMD16_LEN = 6;
    localparam logic [PC_W-1:0] UC_READ   = 6'd0;
    localparam logic [PC_W-1:0] UC_PROG   = 6'd3;
    localparam logic [PC_W-1:0] UC_SE_A   = 6'd11;
    localparam logic [PC_W-1:0] UC_SE_B   = 6'd17;
    localparam logic [PC_W-1:0] UC_SE_W   = 6'd23;
    localparam logic [PC_W-1:0] UC_CE_A   = 6'd24;
    localparam logic [PC_W-1:0] UC_CE_B   = 6'd30;
    localparam logic [PC_W-1:0] UC_CE_W   = 6'd36;
    localparam logic [PC_W-1:0] UC_ID_A   = 6'd37;
    localparam logic [PC_W-1:0] UC_ID_W1  = 6'd43;
    localparam logic [PC_W-1:0] UC_ID_R0  = 6'd44;
    localparam logic [PC_W-1:0] UC_ID_B   = 6'd50;
    localparam logic [PC_W-1:0] UC_ID_W2  = 6'd56;
    localparam logic [PC_W-1:0] UC_DEPTH  = 6'd57;
    localparam logic [PC_W-1:0] UC_PROG_E = 6'd11;

    function automatic t_uword uc_word(input logic [2:0] ph, input t_ad_sel asel,
                                       input logic [15:0] imm, input t_lane_sel ls,
                                       input t_pulse_sel ps, input t_rec_sel rs);
        t_uword w;
        w.ph        = ph;
        w.ad_sel    = asel;
        w.imm       = imm;
        w.lane_sel  = ls;
        w.pulse_sel = ps;
        w.rec_sel   = rs;
        w.loop      = 1'b0;
        w.target    = '0;
        w.last      = 1'b0;
        return w;
    endfunction

    function automatic t_uword uc_latch(input t_ad_sel asel, input logic [15:0] imm);
        return uc_word(PH_LATCH, asel, imm, LS_NONE, PS_ALE, RS_ALE);
    endfunction

    function automatic t_uword uc_write(input t_ad_sel asel, input logic [15:0] imm);
        return uc_word(PH_WRITE, asel, imm, LS_HALF, PS_TWP, RS_TWP);
    endfunction

    function automatic t_uword uc_read(input t_lane_sel ls);
        return uc_word(PH_READ, AD_IMM, 16'h0000, ls, PS_TRD, RS_TRD);
    endfunction

    function automatic t_uword uc_wait(input t_rec_sel rs, input logic last);
        t_uword w;
        w      = uc_word(PH_WAIT, AD_IMM, 16'h0000, LS_NONE, PS_ZERO, rs);
        w.last = last;
        return w;
    endfunction

    // Step k of one unlocked command to one half. The last step runs the
    // block again for the lower half.
    function automatic t_uword uc_cmd(input logic [2:0] k, input t_ad_sel asel,
                                      input logic [15:0] aimm, input t_ad_sel csel,
                                      input logic [15:0] cimm,
                                      input logic [PC_W-1:0] tgt);
        t_uword w;
        case (k)
            3'd0:    w = uc_latch(AD_IMM, ADDR_UNLOCK1);
            3'd1:    w = uc_write(AD_IMM, DATA_UNLOCK1);
            3'd2:    w = uc_latch(AD_IMM, ADDR_UNLOCK2);
            3'd3:    w = uc_write(AD_IMM, DATA_UNLOCK2);
            3'd4:    w = uc_latch(asel, aimm);
            3'd5: begin
                w        = uc_write(csel, cimm);
                w.loop   = 1'b1;
                w.target = tgt;
            end
            default: w = uc_latch(AD_IMM, ADDR_UNLOCK1);
        endcase
        return w;
    endfunction

    function automatic logic in_blk(input logic [PC_W-1:0] a,
                                    input logic [PC_W-1:0] base);
        return (a >= base) && (a < base + PC_W'(CMD16_LEN));
    endfunction

    function automatic t_uword uc_rom(input logic [PC_W-1:0] a);
        t_uword w;
        logic [2:0] k;
        w = uc_wait(RS_ALE, 1'b1);
        k = 3'(a - UC_PROG);
        if (a >= UC_PROG && a < UC_PROG_E) begin
            if (k < 3'(CMD16_LEN)) begin
                w      = uc_cmd(k, AD_IMM, ADDR_UNLOCK1, AD_IMM, CW_PROGRAM, UC_PROG);
                w.loop = 1'b0;
            end else if (k == 3'(CMD16_LEN)) begin
                w = uc_latch(AD_WADDR, 16'h0000);
            end else begin
                w = uc_word(PH_PROG, AD_DATA, 16'h0000, LS_HALF, PS_TWP, RS_TPROG);
                w.loop   = 1'b1;
                w.target = UC_PROG;
                w.last   = 1'b1;
            end
        end else if (in_blk(a, UC_SE_A)) begin
            w = uc_cmd(3'(a - UC_SE_A), AD_IMM, ADDR_UNLOCK1, AD_IMM, CW_ERASE_SETUP,
                       UC_SE_A);
        end else if (in_blk(a, UC_SE_B)) begin
            w = uc_cmd(3'(a - UC_SE_B), AD_EADDR, 16'h0000, AD_ECODE, 16'h0000,
                       UC_SE_B);
        end else if (in_blk(a, UC_CE_A)) begin
            w = uc_cmd(3'(a - UC_CE_A), AD_IMM, ADDR_UNLOCK1, AD_IMM, CW_ERASE_SETUP,
                       UC_CE_A);
        end else if (in_blk(a, UC_CE_B)) begin
            w = uc_cmd(3'(a - UC_CE_B), AD_IMM, ADDR_UNLOCK1, AD_IMM, CW_CHIP_ERASE,
                       UC_CE_B);
        end else if (in_blk(a, UC_ID_A)) begin
            w = uc_cmd(3'(a - UC_ID_A), AD_IMM, ADDR_UNLOCK1, AD_IMM, CW_ID_ENTRY,
                       UC_ID_A);
        end else if (in_blk(a, UC_ID_B)) begin
            w = uc_cmd(3'(a - UC_ID_B), AD_IMM, ADDR_UNLOCK1, AD_IMM, CW_ID_EXIT,
                       UC_ID_B);
        end else begin
            case (a)
                UC_READ:          w = uc_latch(AD_WADDR, 16'h0000);
                UC_READ + 6'd1:   w = uc_read(LS_HI);
                UC_READ + 6'd2: begin
                    w      = uc_read(LS_LO);
                    w.last = 1'b1;
                end
                UC_SE_W:          w = uc_wait(RS_TSE, 1'b1);
                UC_CE_W:          w = uc_wait(RS_TCE, 1'b1);
                UC_ID_W1:         w = uc_wait(RS_TID, 1'b0);
                UC_ID_R0:         w = uc_latch(AD_IMM, ADDR_ID_WORD0);
                UC_ID_R0 + 6'd1:  w = uc_read(LS_HI);
                UC_ID_R0 + 6'd2:  w = uc_read(LS_LO);
                UC_ID_R0 + 6'd3:  w = uc_latch(AD_IMM, ADDR_ID_WORD1);
                UC_ID_R0 + 6'd4:  w = uc_read(LS_HI);
                UC_ID_R0 + 6'd5:  w = uc_read(LS_LO);
                UC_ID_W2:         w = uc_wait(RS_TID, 1'b1);
                default:          w = uc_wait(RS_ALE, 1'b1);
            endcase
        end
        return w;
    endfunction

    function automatic logic uc_cmd_ok(input logic [2:0] cmd);
        return (cmd == CMD_READ) || (cmd == CMD_PROGRAM) || (cmd == CMD_SE_ERASE) ||
               (cmd == CMD_CH_ERASE) || (cmd == CMD_IDENTIFY);
    endfunction

    function automatic logic [PC_W-1:0] uc_entry(input logic [2:0] cmd);
        logic [PC_W-1:0] e;
        case (cmd)
            CMD_READ:     e = UC_READ;
            CMD_PROGRAM:  e = UC_PROG;
            CMD_SE_ERASE: e = UC_SE_A;
            CMD_CH_ERASE: e = UC_CE_A;
            CMD_IDENTIFY: e = UC_ID_A;
            default:      e = UC_READ;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/nfcs_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_seq
// Microcode step counter: fetches one control word per cycle, walks the
// program of the accepted operation and runs each command block twice, once
// per flash half.
// ----------------------------------------------------------------------------
module nfcs_seq (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [2:0] i_cmd,
    output nfcs_pkg::t_ctl  o_ctl,
    output logic            o_busy
);

    logic                          r_busy, n_busy;
    logic                          r_half, n_half;
    logic [nfcs_pkg::PC_W-1:0]     r_pc, n_pc;
    nfcs_pkg::t_uword              w_uw;

    assign w_uw = nfcs_pkg::uc_rom(r_pc);

    always_comb begin
        n_busy = r_busy;
        n_half = r_half;
        n_pc   = r_pc;
        if (r_busy) begin
            if (w_uw.loop && !r_half) begin
                n_pc   = w_uw.target;
                n_half = 1'b1;
            end else if (w_uw.last) begin
                n_busy = 1'b0;
                n_half = 1'b0;
            end else begin
                n_pc = r_pc + nfcs_pkg::PC_W'(1);
                if (w_uw.loop) begin
                    n_half = 1'b0;
                end
            end
        end else if (i_accept && nfcs_pkg::uc_cmd_ok(i_cmd)) begin
            n_busy = 1'b1;
            n_half = 1'b0;
            n_pc   = nfcs_pkg::uc_entry(i_cmd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_half <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_half <= n_half;
            r_pc   <= n_pc;
        end
    end

    assign o_busy      = r_busy;
    assign o_ctl.issue = r_busy;
    assign o_ctl.half  = r_half;
    assign o_ctl.uw    = w_uw;

endmodule
`default_nettype wire

FILE: hw/rtl/nfcs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_dp
// Datapath: timing registers, operand registers and the result register that
// the control word steers.
// ----------------------------------------------------------------------------
module nfcs_dp #(
    parameter int ALE_HIGH_CYCLES = nfcs_pkg::ALE_HIGH_CYCLES_DEF,
    parameter int ALE_LOW_CYCLES  = nfcs_pkg::ALE_LOW_CYCLES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [nfcs_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [nfcs_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                       i_accept,
    input  wire nfcs_pkg::t_req             i_req,
    input  wire nfcs_pkg::t_ctl             i_ctl,
    output logic                            o_res_valid,
    output nfcs_pkg::t_res                  o_res
);

    logic [nfcs_pkg::T_W-1:0]  r_t_read, r_t_wp, r_t_prog, r_t_id, r_t_se, r_t_ce;
    logic [nfcs_pkg::SS_W-1:0] r_sector_size;
    logic [nfcs_pkg::EC_W-1:0] r_erase_code;

    logic [nfcs_pkg::AD_W-1:0] r_waddr, r_eaddr;
    logic [31:0]               r_data;

    logic                      r_res_valid;
    nfcs_pkg::t_res            r_res, n_res;

    logic [26:0]               w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_read      <= nfcs_pkg::RST_T_READ;
            r_t_wp        <= nfcs_pkg::RST_T_WPULSE;
            r_t_prog      <= nfcs_pkg::RST_T_PROGRAM;
            r_t_id        <= nfcs_pkg::RST_T_ID_ACCESS;
            r_t_se        <= nfcs_pkg::RST_T_SE_ERASE;
            r_t_ce        <= nfcs_pkg::RST_T_CH_ERASE;
            r_sector_size <= nfcs_pkg::RST_SECTOR_SIZE;
            r_erase_code  <= nfcs_pkg::RST_ERASE_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nfcs_pkg::REG_T_READ:      r_t_read      <= i_cfg_data;
                nfcs_pkg::REG_T_WPULSE:    r_t_wp        <= i_cfg_data;
                nfcs_pkg::REG_T_PROGRAM:   r_t_prog      <= i_cfg_data;
                nfcs_pkg::REG_T_ID_ACCESS: r_t_id        <= i_cfg_data;
                nfcs_pkg::REG_T_SE_ERASE:  r_t_se        <= i_cfg_data;
                nfcs_pkg::REG_T_CH_ERASE:  r_t_ce        <= i_cfg_data;
                nfcs_pkg::REG_SECTOR_SIZE: r_sector_size <= i_cfg_data[nfcs_pkg::SS_W-1:0];
                nfcs_pkg::REG_ERASE_CODE:  r_erase_code  <= i_cfg_data[nfcs_pkg::EC_W-1:0];
                default: ;
            endcase
        end
    end

    // The erase address is formed once, when the operation is taken in.
    assign w_prod = 27'(i_req.sector) * 27'(r_sector_size);

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_waddr <= i_req.byte_addr[20:2];
            r_data  <= i_req.data_word;
            r_eaddr <= w_prod[nfcs_pkg::AD_W-1:0];
        end
    end

    always_comb begin
        n_res.phase = i_ctl.uw.ph;

        case (i_ctl.uw.ad_sel)
            nfcs_pkg::AD_IMM:   n_res.ad_value = {3'b000, i_ctl.uw.imm};
            nfcs_pkg::AD_WADDR: n_res.ad_value = r_waddr;
            nfcs_pkg::AD_EADDR: n_res.ad_value = r_eaddr;
            nfcs_pkg::AD_DATA:  n_res.ad_value = i_ctl.half ? {3'b000, r_data[15:0]}
                                                            : {3'b000, r_data[31:16]};
            nfcs_pkg::AD_ECODE: n_res.ad_value = {3'b000, r_erase_code};
            default:            n_res.ad_value = '0;
        endcase

        case (i_ctl.uw.lane_sel)
            nfcs_pkg::LS_HI:   n_res.lanes = nfcs_pkg::LANE_HI;
            nfcs_pkg::LS_LO:   n_res.lanes = nfcs_pkg::LANE_LO;
            nfcs_pkg::LS_HALF: n_res.lanes = i_ctl.half ? nfcs_pkg::LANE_LO
                                                        : nfcs_pkg::LANE_HI;
            default:           n_res.lanes = nfcs_pkg::LANE_NONE;
        endcase

        case (i_ctl.uw.pulse_sel)
            nfcs_pkg::PS_ALE: n_res.pulse_cycles = nfcs_pkg::T_W'(ALE_HIGH_CYCLES);
            nfcs_pkg::PS_TWP: n_res.pulse_cycles = r_t_wp;
            nfcs_pkg::PS_TRD: n_res.pulse_cycles = r_t_read;
            default:          n_res.pulse_cycles = '0;
        endcase

        case (i_ctl.uw.rec_sel)
            nfcs_pkg::RS_ALE:   n_res.recovery_cycles = nfcs_pkg::T_W'(ALE_LOW_CYCLES);
            nfcs_pkg::RS_TWP:   n_res.recovery_cycles = r_t_wp;
            nfcs_pkg::RS_TRD:   n_res.recovery_cycles = r_t_read;
            nfcs_pkg::RS_TPROG: n_res.recovery_cycles = r_t_prog;
            nfcs_pkg::RS_TID:   n_res.recovery_cycles = r_t_id;
            nfcs_pkg::RS_TSE:   n_res.recovery_cycles = r_t_se;
            nfcs_pkg::RS_TCE:   n_res.recovery_cycles = r_t_ce;
            default:            n_res.recovery_cycles = '0;
        endcase

        // A looping word is only final on its pass for the lower half.
        n_res.last = i_ctl.uw.last && !(i_ctl.uw.loop && !i_ctl.half);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

FILE: hw/rtl/nor_flash_command_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer_core
// Turns one flash operation into its ordered list of bus phase words.
// The first word reaches the outputs after start is taken, through the step
// counter and then the result register. Throughput: one word per cycle from
// the microcode step counter; an operation has 3, 16, 25, 25 or 32 words.
// A new operation is taken in the cycle that the last word is shown.
// The receiver cannot stall; every word holds for exactly one cycle.
// Reset loads the default timing registers and leaves the sequencer idle.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer_core #(
    parameter int ALE_HIGH_CYCLES = nfcs_pkg::ALE_HIGH_CYCLES_DEF,
    parameter int ALE_LOW_CYCLES  = nfcs_pkg::ALE_LOW_CYCLES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [nfcs_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [nfcs_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                       start,
    output logic                            busy,
    input  wire nfcs_pkg::t_req             i_req,
    output logic                            o_res_valid,
    output nfcs_pkg::t_res                  o_res
);

    logic           w_accept;
    nfcs_pkg::t_ctl w_ctl;

    assign w_accept = start && !busy;

    nfcs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_cmd    (i_req.cmd),
        .o_ctl    (w_ctl),
        .o_busy   (busy)
    );

    nfcs_dp #(
        .ALE_HIGH_CYCLES (ALE_HIGH_CYCLES),
        .ALE_LOW_CYCLES  (ALE_LOW_CYCLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_req       (i_req),
        .i_ctl       (w_ctl),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Every word comes from a step issued while the sequencer was running.
    a_word_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("word shown without a running operation");

    a_valid_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && nfcs_pkg::uc_cmd_ok(i_req.cmd)) |=> busy)
        else $error("valid operation did not start");

    a_bad_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !nfcs_pkg::uc_cmd_ok(i_req.cmd)) |=> !busy && !o_res_valid)
        else $error("unknown operation produced activity");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy)
        else $error("final word shown while still running");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (u_seq.r_pc < nfcs_pkg::UC_DEPTH))
        else $error("step counter left the microcode program");

endmodule
`default_nettype wire
